### rtl/core/nld_pkg.sv
// nld_pkg: shared sizes, types and codes for the nearest lift dispatcher
// used by nld_table and nearest_lift_dispatch; no dependencies
package nld_pkg;

  // group size and building height
  localparam int NUM_LIFTS  = 8;
  localparam int NUM_FLOORS = 64;

  // field widths fixed by the item format
  localparam int FLOOR_W = 6;
  localparam int DIR_W   = 2;
  localparam int IDX_W   = 3;
  localparam int CLASS_W = 2;

  // table addressing and scan counter widths
  localparam int LIFT_AW = (NUM_LIFTS > 1) ? $clog2(NUM_LIFTS) : 1;
  localparam int CNT_W   = $clog2(NUM_LIFTS + 1);

  typedef logic [LIFT_AW-1:0]      addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [FLOOR_W-1:0]      floor_t;
  typedef logic signed [DIR_W-1:0] dir_t;

  // top floor, the saturation value for an update floor above it
  localparam floor_t FLOOR_MAX = FLOOR_W'(NUM_FLOORS - 1);

  // direction codes
  localparam dir_t DIR_UP   = 2'sb01;
  localparam dir_t DIR_DOWN = 2'sb11;
  localparam dir_t DIR_IDLE = 2'sb00;

  // result classes
  typedef enum logic [CLASS_W-1:0] {
    MC_WAY      = 2'd0,
    MC_IDLE     = 2'd1,
    MC_FALLBACK = 2'd2
  } match_class_t;

  // table write request
  typedef struct packed {
    logic   en;
    addr_t  addr;
    floor_t flr;
    dir_t   dir;
  } tbl_wr_t;

  // table read request
  typedef struct packed {
    logic  en;
    addr_t addr;
  } tbl_rd_t;

endpackage

### rtl/core/nearest_lift_dispatch.sv
// nearest_lift_dispatch: hall call dispatcher over a table of lift states
// depends on nld_pkg and nld_table
//
//   channel  ports                                          dir   handshake
//   in       in_mode, in_lift_index, in_lift_floor,         in    in_valid / in_stall
//            in_lift_direction, in_call_floor, in_call_direction
//   out      out_chosen_lift, out_match_class,              out   out_valid / out_stall
//            out_floor_distance
//
// a status item is written to the table in the cycle it is taken
// a call item reads the table one lift per cycle through its single read
// port, then its result is loaded into the output register once that is free
// reset is synchronous; the table reads as all floors 0, all idle after it
// a waiting result holds in the output register while the next call scans;
// the scan result waits for that register to drain
module nearest_lift_dispatch (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [nld_pkg::IDX_W-1:0]    in_lift_index,
  input  logic [nld_pkg::FLOOR_W-1:0]  in_lift_floor,
  input  logic signed [nld_pkg::DIR_W-1:0] in_lift_direction,
  input  logic [nld_pkg::FLOOR_W-1:0]  in_call_floor,
  input  logic signed [nld_pkg::DIR_W-1:0] in_call_direction,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nld_pkg::IDX_W-1:0]    out_chosen_lift,
  output logic [nld_pkg::CLASS_W-1:0]  out_match_class,
  output logic [nld_pkg::FLOOR_W-1:0]  out_floor_distance
);
  import nld_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t       state_r, state_nxt;
  floor_t       cf_r;
  dir_t         cd_r;
  cnt_t         scan_cnt_r, scan_cnt_nxt;
  logic         eval_vld_r;
  addr_t        eval_idx_r;

  logic         way_found_r, idle_found_r;
  addr_t        way_idx_r, idle_idx_r;
  floor_t       way_dist_r, idle_dist_r;

  logic         out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_lift_r;
  match_class_t out_class_r;
  floor_t       out_dist_r;

  logic         accept, call_acc, load_out, out_free;
  tbl_wr_t      wr;
  tbl_rd_t      rd;
  floor_t       lf, gap;
  dir_t         ld;
  logic         on_way, take_way, take_idle;

  // handshake
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign call_acc = accept && in_mode;

  // status write, out-of-range lifts dropped, floor saturated
  always_comb begin
    wr.en   = accept && !in_mode && (int'(in_lift_index) < NUM_LIFTS);
    wr.addr = LIFT_AW'(in_lift_index);
    wr.flr  = (int'(in_lift_floor) > NUM_FLOORS - 1) ? FLOOR_MAX : in_lift_floor;
    wr.dir  = in_lift_direction;
  end

  // scan read, one lift per cycle
  always_comb begin
    rd.en   = (state_r == S_SCAN) && (scan_cnt_r < CNT_W'(NUM_LIFTS));
    rd.addr = scan_cnt_r[LIFT_AW-1:0];
  end

  nld_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd       (rd),
    .rd_floor (lf),
    .rd_dir   (ld)
  );

  // candidate test on the entry just read
  always_comb begin
    gap    = (lf > cf_r) ? (lf - cf_r) : (cf_r - lf);
    on_way = ((cd_r == DIR_UP) && (ld == DIR_UP) && (cf_r > lf)) ||
             ((cd_r == DIR_DOWN) && (ld == DIR_DOWN) && (cf_r < lf));
    take_way  = eval_vld_r && on_way && (!way_found_r || (gap < way_dist_r));
    take_idle = eval_vld_r && !on_way && (ld == DIR_IDLE) &&
                (!idle_found_r || (gap < idle_dist_r));
  end

  // sequencer
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    load_out     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (call_acc) begin
          state_nxt    = S_SCAN;
          scan_cnt_nxt = '0;
        end
      end
      S_SCAN: begin
        if (rd.en) begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end else if (!eval_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_cnt_r   <= '0;
      eval_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      way_found_r  <= 1'b0;
      idle_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      eval_vld_r  <= rd.en;
      out_valid_r <= out_valid_nxt;
      if (call_acc) begin
        way_found_r  <= 1'b0;
        idle_found_r <= 1'b0;
      end else begin
        if (take_way) begin
          way_found_r <= 1'b1;
        end
        if (take_idle) begin
          idle_found_r <= 1'b1;
        end
      end
    end
  end

  // call fields, best candidates and result
  always_ff @(posedge clk) begin
    if (call_acc) begin
      cf_r <= in_call_floor;
      cd_r <= in_call_direction;
    end
    eval_idx_r <= rd.addr;
    if (take_way) begin
      way_idx_r  <= eval_idx_r;
      way_dist_r <= gap;
    end
    if (take_idle) begin
      idle_idx_r  <= eval_idx_r;
      idle_dist_r <= gap;
    end
    if (load_out) begin
      if (way_found_r) begin
        out_lift_r  <= IDX_W'(way_idx_r);
        out_class_r <= MC_WAY;
        out_dist_r  <= way_dist_r;
      end else if (idle_found_r) begin
        out_lift_r  <= IDX_W'(idle_idx_r);
        out_class_r <= MC_IDLE;
        out_dist_r  <= idle_dist_r;
      end else begin
        out_lift_r  <= '0;
        out_class_r <= MC_FALLBACK;
        out_dist_r  <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chosen_lift    = out_lift_r;
  assign out_match_class    = out_class_r;
  assign out_floor_distance = out_dist_r;

  // checks
  a_fallback_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_match_class == MC_FALLBACK) |->
      (out_chosen_lift == '0) && (out_floor_distance == '0))
    else $error("fallback result not lift 0 at distance 0");

  a_class_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_class == MC_WAY) || (out_match_class == MC_IDLE) ||
                  (out_match_class == MC_FALLBACK))
    else $error("undefined match class on a valid result");

  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    eval_vld_r |-> (state_r == S_SCAN))
    else $error("table entry evaluated outside a scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_cnt_r <= CNT_W'(NUM_LIFTS)))
    else $error("scan counter ran past the lift count");

endmodule

### rtl/core/nld_table.sv
// nld_table: lift status memory, one write and one registered read per cycle
// depends on nld_pkg; entries never written read as floor 0, idle
module nld_table (
  input  logic             clk,
  input  logic             rst_n,
  input  nld_pkg::tbl_wr_t wr,
  input  nld_pkg::tbl_rd_t rd,
  output nld_pkg::floor_t  rd_floor,
  output nld_pkg::dir_t    rd_dir
);
  import nld_pkg::*;

  localparam int ENTRY_W = FLOOR_W + DIR_W;

  logic [ENTRY_W-1:0]   mem [NUM_LIFTS];
  logic [NUM_LIFTS-1:0] valid_r;
  logic [ENTRY_W-1:0]   rd_data_r;
  logic                 rd_ok_r;

  // storage array, written and read in the clock
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.flr, wr.dir};
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  // per-entry written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_ok_r <= valid_r[rd.addr];
      end
    end
  end

  // unwritten entries read as the reset value
  assign rd_floor = rd_ok_r ? rd_data_r[ENTRY_W-1:DIR_W] : '0;
  assign rd_dir   = rd_ok_r ? dir_t'(rd_data_r[DIR_W-1:0]) : DIR_IDLE;

endmodule

### tb/sv/tb_nearest_lift_dispatch.sv
// tb_nearest_lift_dispatch: self-checking bench for the hall call dispatcher
// depends on nld_pkg and nearest_lift_dispatch; drives status and call items,
// predicts each lift choice and checks every result against it
`timescale 1ns / 1ps

module tb_nearest_lift_dispatch;
  import nld_pkg::*;

  // odd direction pattern, neither moving nor idle
  localparam dir_t DIR_ODD = 2'sb10;
  localparam logic MODE_STATUS = 1'b0;
  localparam logic MODE_CALL   = 1'b1;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int TAIL_CYCLES  = 30;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] lift;
    floor_t           flr;
    dir_t             heading;
    floor_t           call_flr;
    dir_t             call_dir;
  } hall_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] lift;
    match_class_t     cls;
    floor_t           gap;
  } lift_choice_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_mode = MODE_STATUS;
  logic [IDX_W-1:0] in_lift_index = '0;
  floor_t           in_lift_floor = '0;
  dir_t             in_lift_direction = DIR_IDLE;
  floor_t           in_call_floor = '0;
  dir_t             in_call_direction = DIR_IDLE;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] out_chosen_lift;
  logic [CLASS_W-1:0] out_match_class;
  floor_t           out_floor_distance;

  // items waiting to be driven and lift choices waiting to come out
  hall_item_t   item_queue[$];
  lift_choice_t due_choices[$];

  // predicted lift table
  floor_t floor_of_lift[NUM_LIFTS];
  dir_t   heading_of_lift[NUM_LIFTS];

  int   cycle_count = 0;
  logic steady_phase;
  int   items_queued = 0;
  int   items_taken = 0;
  int   calls_taken = 0;
  int   mismatches = 0;
  int   class_seen[3] = '{0, 0, 0};

  nearest_lift_dispatch DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_lift_index      (in_lift_index),
    .in_lift_floor      (in_lift_floor),
    .in_lift_direction  (in_lift_direction),
    .in_call_floor      (in_call_floor),
    .in_call_direction  (in_call_direction),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_chosen_lift    (out_chosen_lift),
    .out_match_class    (out_match_class),
    .out_floor_distance (out_floor_distance)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // nearest lift on the way, else nearest idle lift, else lift 0
  function automatic lift_choice_t assign_hall_call(floor_t call_flr, dir_t call_dir);
    lift_choice_t pick;
    logic way_found, idle_found, on_way;
    int way_lift, idle_lift, way_dist, idle_dist, lf, cf, d;
    way_found = 1'b0;
    idle_found = 1'b0;
    way_lift = 0;
    idle_lift = 0;
    way_dist = 0;
    idle_dist = 0;
    cf = int'(call_flr);
    for (int k = 0; k < NUM_LIFTS; k++) begin
      lf = int'(floor_of_lift[k]);
      d = (lf > cf) ? lf - cf : cf - lf;
      on_way = (call_dir == DIR_UP && heading_of_lift[k] == DIR_UP && cf > lf) ||
               (call_dir == DIR_DOWN && heading_of_lift[k] == DIR_DOWN && cf < lf);
      if (on_way) begin
        if (!way_found || d < way_dist) begin
          way_found = 1'b1;
          way_lift = k;
          way_dist = d;
        end
      end else if (heading_of_lift[k] == DIR_IDLE) begin
        if (!idle_found || d < idle_dist) begin
          idle_found = 1'b1;
          idle_lift = k;
          idle_dist = d;
        end
      end
    end
    if (way_found) begin
      pick.lift = IDX_W'(way_lift);
      pick.cls = MC_WAY;
      pick.gap = FLOOR_W'(way_dist);
    end else if (idle_found) begin
      pick.lift = IDX_W'(idle_lift);
      pick.cls = MC_IDLE;
      pick.gap = FLOOR_W'(idle_dist);
    end else begin
      pick.lift = '0;
      pick.cls = MC_FALLBACK;
      pick.gap = '0;
    end
    return pick;
  endfunction

  task automatic queue_status(input int lift, input floor_t flr, input dir_t heading);
    hall_item_t it;
    it = '0;
    it.mode = MODE_STATUS;
    it.lift = IDX_W'(lift);
    it.flr = flr;
    it.heading = heading;
    // unused call fields still toggle
    it.call_flr = FLOOR_W'($urandom);
    it.call_dir = DIR_W'($urandom);
    item_queue.insert(item_queue.size(), it);
    items_queued++;
  endtask

  task automatic queue_call(input floor_t call_flr, input dir_t call_dir);
    hall_item_t it;
    it = '0;
    it.mode = MODE_CALL;
    it.lift = IDX_W'($urandom);
    it.flr = FLOOR_W'($urandom);
    it.heading = DIR_W'($urandom);
    it.call_flr = call_flr;
    it.call_dir = call_dir;
    item_queue.insert(item_queue.size(), it);
    items_queued++;
  endtask

  // floors lean to the ends and to a narrow band so ties turn up
  function automatic floor_t pick_floor();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return FLOOR_MAX;
    if (r < 50) return FLOOR_W'($urandom_range(28, 35));
    return FLOOR_W'($urandom_range(0, NUM_FLOORS - 1));
  endfunction

  function automatic dir_t pick_heading(input logic for_call);
    int r;
    r = $urandom_range(0, 99);
    if (for_call) begin
      if (r < 45) return DIR_UP;
      if (r < 90) return DIR_DOWN;
      if (r < 95) return DIR_IDLE;
      return DIR_ODD;
    end
    if (r < 35) return DIR_UP;
    if (r < 70) return DIR_DOWN;
    if (r < 92) return DIR_IDLE;
    return DIR_ODD;
  endfunction

  // cycle count, steady window and run limit
  assign steady_phase = (cycle_count >= 2000) && (cycle_count < 3500);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d items taken, %0d results pending",
               cycle_count, items_taken, items_queued, due_choices.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // item driver with random gaps outside the steady window
  always @(posedge clk) begin : driver
    hall_item_t next_item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (item_queue.size() != 0 && (steady_phase || $urandom_range(0, 99) >= 33)) begin
        next_item = item_queue.pop_front();
        in_valid <= 1'b1;
        in_mode <= next_item.mode;
        in_lift_index <= next_item.lift;
        in_lift_floor <= next_item.flr;
        in_lift_direction <= next_item.heading;
        in_call_floor <= next_item.call_flr;
        in_call_direction <= next_item.call_dir;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady_phase && ($urandom_range(0, 99) < 33);
    end
  end

  // predict on accepted items, check accepted results
  always @(posedge clk) begin : monitor
    lift_choice_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (in_mode == MODE_STATUS) begin
          floor_of_lift[in_lift_index] = (in_lift_floor > FLOOR_MAX) ? FLOOR_MAX
                                                                      : in_lift_floor;
          heading_of_lift[in_lift_index] = in_lift_direction;
        end else begin
          due_choices.insert(due_choices.size(),
                             assign_hall_call(in_call_floor, in_call_direction));
          calls_taken++;
        end
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (due_choices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: lift %0d class %0d distance %0d",
                     out_chosen_lift, out_match_class, out_floor_distance);
        end else begin
          want = due_choices.pop_front();
          class_seen[want.cls]++;
          if (out_chosen_lift !== want.lift || out_match_class !== want.cls ||
              out_floor_distance !== want.gap) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected lift %0d class %0d distance %0d, got %0d %0d %0d",
                       want.lift, want.cls, want.gap,
                       out_chosen_lift, out_match_class, out_floor_distance);
          end
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < NUM_LIFTS; k++) begin
      floor_of_lift[k] = '0;
      heading_of_lift[k] = DIR_IDLE;
    end

    // directed: all idle at floor 0, far call picks lift 0
    queue_call(FLOOR_MAX, DIR_UP);
    queue_status(7, FLOOR_MAX, DIR_DOWN);
    queue_status(3, 6'd10, DIR_UP);
    // lifts on the way up and down
    queue_call(6'd20, DIR_UP);
    queue_call(6'd0, DIR_DOWN);
    // moving lift already at the calling floor does not count
    queue_call(6'd10, DIR_UP);
    // call without a proper direction searches idle lifts only
    queue_call(6'd5, DIR_IDLE);
    queue_call(6'd5, DIR_ODD);
    queue_status(5, 6'd40, DIR_DOWN);
    queue_call(6'd20, DIR_DOWN);
    // equal distance, lowest index wins
    queue_status(2, 6'd30, DIR_UP);
    queue_status(6, 6'd30, DIR_UP);
    queue_call(6'd40, DIR_UP);
    // no idle lift left: fallback to lift 0
    queue_status(1, 6'd12, DIR_ODD);
    queue_status(0, 6'd0, DIR_UP);
    queue_status(4, FLOOR_MAX, DIR_ODD);
    queue_call(6'd0, DIR_UP);
    queue_call(FLOOR_MAX, DIR_DOWN);
    // idle lift at the calling floor wins with distance 0
    queue_status(4, 6'd33, DIR_IDLE);
    queue_call(6'd33, DIR_ODD);
    queue_call(FLOOR_MAX, DIR_UP);
    queue_status(7, 6'd0, DIR_IDLE);
    queue_call(6'd0, DIR_IDLE);

    // random status and call mix
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 45)
        queue_status($urandom_range(0, NUM_LIFTS - 1), pick_floor(), pick_heading(1'b0));
      else
        queue_call(pick_floor(), pick_heading(1'b1));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all items taken, all results back, then latency tail
    wait (items_taken == items_queued);
    while (due_choices.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items taken: %0d status updates, %0d hall calls",
             items_taken, items_taken - calls_taken, calls_taken);
    $display("choices checked: %0d on the way, %0d idle, %0d fallback, %0d mismatches",
             class_seen[MC_WAY], class_seen[MC_IDLE], class_seen[MC_FALLBACK], mismatches);
    if (mismatches == 0 && due_choices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### nearest_lift_dispatch.f
rtl/core/nld_pkg.sv
rtl/core/nld_table.sv
rtl/core/nearest_lift_dispatch.sv
tb/sv/tb_nearest_lift_dispatch.sv
